// ----- sv/led_breath_flash_controller_unit_assert.svh -----
// ----------------------------------------------------------------------------
// LED breath/flash controller assertion macros
// Concurrent check wrappers, empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef LED_BREATH_FLASH_CONTROLLER_UNIT_ASSERT_SVH
`define LED_BREATH_FLASH_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property at every clock edge outside reset
`define LBF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lbf assertion failed");

// Check that a condition implies a consequence in the next cycle
`define LBF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("lbf assertion failed");

`else

`define LBF_ASSERT(label, clk, rst_n, prop)
`define LBF_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ----- sv/lbf_pkg.sv -----
// ----------------------------------------------------------------------------
// LED breath/flash controller package
// Shared types, register indexes, reset values and mode codes.
// ----------------------------------------------------------------------------
package lbf_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_INCR      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BREATH_INTVL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD    = 3'd4;

	// Register reset values
	localparam logic [15:0] RST_PWM_TOP      = 16'd999;
	localparam logic [15:0] RST_RAMP_INCR    = 16'd10;
	localparam logic [15:0] RST_BREATH_INTVL = 16'd10;
	localparam logic [15:0] RST_FAST_PERIOD  = 16'd500;
	localparam logic [15:0] RST_SLOW_PERIOD  = 16'd1000;

	// Requested mode codes on the request stream
	localparam logic [2:0] MODE_OFF     = 3'd0;
	localparam logic [2:0] MODE_ON      = 3'd1;
	localparam logic [2:0] MODE_BREATHE = 3'd2;
	localparam logic [2:0] MODE_FAST    = 3'd3;
	localparam logic [2:0] MODE_SLOW    = 3'd4;

	// Request kinds
	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_SET    = 1'b1;

	// Active LED mode, one-hot
	typedef enum logic [4:0] {
		ST_OFF     = 5'b00001,
		ST_ON      = 5'b00010,
		ST_BREATHE = 5'b00100,
		ST_FAST    = 5'b01000,
		ST_SLOW    = 5'b10000
	} led_state_t;

	typedef struct packed {
		logic [15:0] pwm_top;
		logic [15:0] ramp_incr;
		logic [15:0] breath_intvl;
		logic [15:0] fast_period;
		logic [15:0] slow_period;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  mode;
		logic [31:0] now_ms;
	} item_t;

	// Map a valid mode code to its one-hot state
	function automatic led_state_t mode_to_state(input logic [2:0] code);
		led_state_t st;
		unique case (code)
			MODE_OFF:     st = ST_OFF;
			MODE_ON:      st = ST_ON;
			MODE_BREATHE: st = ST_BREATHE;
			MODE_FAST:    st = ST_FAST;
			MODE_SLOW:    st = ST_SLOW;
			default:      st = ST_OFF;
		endcase
		return st;
	endfunction

endpackage

// ----- sv/lbf_cfg.sv -----
// ----------------------------------------------------------------------------
// LED breath/flash controller configuration registers
// Write-only register file for the five timing and level settings.
// ----------------------------------------------------------------------------
module lbf_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [lbf_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [15:0]                   wr_data,
	output lbf_pkg::cfg_t                 cfg
);

	lbf_pkg::cfg_t cfg_q;

	// Decode the index and load the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_top      <= lbf_pkg::RST_PWM_TOP;
			cfg_q.ramp_incr    <= lbf_pkg::RST_RAMP_INCR;
			cfg_q.breath_intvl <= lbf_pkg::RST_BREATH_INTVL;
			cfg_q.fast_period  <= lbf_pkg::RST_FAST_PERIOD;
			cfg_q.slow_period  <= lbf_pkg::RST_SLOW_PERIOD;
		end else if (wr_en) begin
			unique case (wr_index)
				lbf_pkg::REG_PWM_TOP:      cfg_q.pwm_top      <= wr_data;
				lbf_pkg::REG_RAMP_INCR:    cfg_q.ramp_incr    <= wr_data;
				lbf_pkg::REG_BREATH_INTVL: cfg_q.breath_intvl <= wr_data;
				lbf_pkg::REG_FAST_PERIOD:  cfg_q.fast_period  <= wr_data;
				lbf_pkg::REG_SLOW_PERIOD:  cfg_q.slow_period  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/lbf_core.sv -----
// ----------------------------------------------------------------------------
// LED breath/flash controller core
// Mode state, breathing ramp and flash toggles; one request per cycle on step.
// ----------------------------------------------------------------------------
`include "led_breath_flash_controller_unit_assert.svh"

module lbf_core (
	input  logic           clk,
	input  logic           arst_n,
	input  lbf_pkg::cfg_t  cfg,
	input  logic           step,
	input  lbf_pkg::item_t item,
	output logic [15:0]    duty
);

	lbf_pkg::led_state_t mode_q, mode_n, tgt;
	logic [31:0] last_q, last_n;
	logic [15:0] bright_q, bright_n;
	logic        ramp_q, ramp_n;
	logic [15:0] level_q, level_n;

	logic [31:0] elapsed;
	logic [16:0] b_sum;
	logic [15:0] b_dec;
	logic [16:0] b_raw;
	logic        hit_top;
	logic [15:0] b_new;
	logic        ramp_new;
	logic [15:0] half;
	logic        mode_ok;
	logic        upd_in_off;
	logic        set_to_off;

	// Elapsed time with wrapping subtraction
	assign elapsed = item.now_ms - last_q;

	// Next breathing level: saturate up, clamp down at zero
	assign b_sum    = {1'b0, bright_q} + {1'b0, cfg.ramp_incr};
	assign b_dec    = (bright_q >= cfg.ramp_incr) ? (bright_q - cfg.ramp_incr) : 16'd0;
	assign b_raw    = ramp_q ? {1'b0, b_dec} : b_sum;
	assign hit_top  = (b_raw >= {1'b0, cfg.pwm_top});
	assign b_new    = hit_top ? cfg.pwm_top : b_raw[15:0];
	assign ramp_new = hit_top ? 1'b1 : ((b_raw == 17'd0) ? 1'b0 : ramp_q);

	// Half flash period for the active flash mode
	assign half = (mode_q == lbf_pkg::ST_FAST) ? {1'b0, cfg.fast_period[15:1]}
	                                           : {1'b0, cfg.slow_period[15:1]};

	assign mode_ok = (item.mode <= lbf_pkg::MODE_SLOW);
	assign tgt     = lbf_pkg::mode_to_state(item.mode);

	// Work out the next state for the request in hand
	always_comb begin
		mode_n   = mode_q;
		last_n   = last_q;
		bright_n = bright_q;
		ramp_n   = ramp_q;
		level_n  = level_q;
		if (item.kind == lbf_pkg::KIND_SET) begin
			if (mode_ok && (tgt != mode_q)) begin
				mode_n = tgt;
				unique case (tgt) inside
					lbf_pkg::ST_OFF: level_n = 16'd0;
					lbf_pkg::ST_ON:  level_n = cfg.pwm_top;
					lbf_pkg::ST_BREATHE: begin
						bright_n = 16'd0;
						ramp_n   = 1'b0;
						last_n   = item.now_ms;
					end
					lbf_pkg::ST_FAST, lbf_pkg::ST_SLOW: begin
						level_n = 16'd0;
						last_n  = item.now_ms;
					end
					default: ;
				endcase
			end
		end else begin
			unique case (mode_q) inside
				lbf_pkg::ST_BREATHE: begin
					if (elapsed >= {16'd0, cfg.breath_intvl}) begin
						last_n   = item.now_ms;
						bright_n = b_new;
						ramp_n   = ramp_new;
						level_n  = b_new;
					end
				end
				lbf_pkg::ST_FAST, lbf_pkg::ST_SLOW: begin
					if (elapsed >= {16'd0, half}) begin
						last_n  = item.now_ms;
						level_n = (level_q == 16'd0) ? cfg.pwm_top : 16'd0;
					end
				end
				default: ;
			endcase
		end
	end

	// Advance the state when a request is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= lbf_pkg::ST_OFF;
			last_q   <= 32'd0;
			bright_q <= 16'd0;
			ramp_q   <= 1'b0;
			level_q  <= 16'd0;
		end else if (step) begin
			mode_q   <= mode_n;
			last_q   <= last_n;
			bright_q <= bright_n;
			ramp_q   <= ramp_n;
			level_q  <= level_n;
		end
	end

	// Clamp the result to the current top
	assign duty = (level_n > cfg.pwm_top) ? cfg.pwm_top : level_n;

	// Request classes watched by the checks below
	assign upd_in_off = step && (item.kind == lbf_pkg::KIND_UPDATE)
		&& (mode_q == lbf_pkg::ST_OFF);
	assign set_to_off = step && (item.kind == lbf_pkg::KIND_SET)
		&& (item.mode == lbf_pkg::MODE_OFF);

	`LBF_ASSERT(a_duty_le_top, clk, arst_n, duty <= cfg.pwm_top)
	`LBF_ASSERT_NEXT(a_off_holds, clk, arst_n, upd_in_off, $stable(level_q))
	`LBF_ASSERT_NEXT(a_set_off_clears, clk, arst_n, set_to_off, level_q == 16'd0)

endmodule

// ----- sv/led_breath_flash_controller_unit.sv -----
// ----------------------------------------------------------------------------
// LED breath/flash controller
// Produces the LED PWM duty for update and set-mode requests.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit first)
// s_axis    in   tuser: kind; tdata: mode[2:0], now_ms[34:3], unused [39:35]
// m_axis    out  tdata: duty[15:0]
// wr        in   wr_index selects register, wr_data written when wr_en
//
// One request per cycle while the result stream is not stalled; each
// request is processed when it moves from the input register into the
// result register, which it does once the result register is free, and
// its duty is then offered from the result register. The state update and
// the clamp sit in a single stage between the two registers.
// Reset clears the mode to off and all levels and timestamps to zero.
// A stalled result holds the result register; the input register keeps
// taking a request as long as the result register can move on.
// ----------------------------------------------------------------------------
module led_breath_flash_controller_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [39:0]                   s_axis_tdata,  // mode[2:0], now_ms[34:3], pad
	input  logic                          s_axis_tuser,  // kind[0]
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,  // duty[15:0]
	input  logic                          wr_en,
	input  logic [lbf_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [15:0]                   wr_data
);

	lbf_pkg::cfg_t  cfg;
	lbf_pkg::item_t item_s1;
	logic           valid_s1;
	logic           out_valid_s2;
	logic [15:0]    duty_s2;
	logic [15:0]    duty;
	logic           advance;
	logic           s_take;

	lbf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Move the held request on when the result register is free
	assign advance       = valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_take        = s_axis_tvalid && s_axis_tready;

	// Input register: hold the request valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_take) begin
			item_s1.kind   <= s_axis_tuser;
			item_s1.mode   <= s_axis_tdata[2:0];
			item_s1.now_ms <= s_axis_tdata[34:3];
		end
	end

	lbf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.item   (item_s1),
		.duty   (duty)
	);

	// Result register: fill on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty_s2 <= duty;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = duty_s2;

endmodule
